// File: hdl/assert_macros.svh
// Assertion macros for the checker file of the sinc3 LUT entry unit.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define S3_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sinc3 lut check failed");

// Consequent must hold in the same cycle as the antecedent.
`define S3_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sinc3 lut check failed");

`endif

// File: hdl/s3lut_pkg.sv
// Shared constants and types for the sinc3 PDM LUT entry unit.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package s3lut_pkg;

  localparam int LANES          = 8;
  localparam int STAGES         = 3;
  localparam int MAX_DECIMATION = 128;
  localparam int RATIO_W        = 8;
  localparam int POS_W          = 9;
  localparam int COEF_W         = 16;
  localparam int SUM_W          = 17;
  localparam int SUM_MAX        = 131071;
  localparam int RATIO_RESET    = 64;

  localparam int APB_DATA_W = 32;
  localparam int ADDR_W     = 3;

  typedef logic [ADDR_W-3:0] reg_idx_t;
  localparam reg_idx_t REG_DECIMATION = reg_idx_t'(0);

  typedef logic [LANES-1:0][COEF_W-1:0] coef_vec_t;

endpackage

`default_nettype wire

// File: hdl/sinc3_pdm_lut_entry_unit.sv
// Top level of the sinc3 PDM decimator LUT entry unit: request register,
// eight coefficient lanes, adder tree and result register. Depends on s3lut_pkg,
// s3lut_coef and s3lut_sum.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------
//   request  | start_i / busy_o     | pdm_byte_i, tap_group_i, stage_index_i
//   result   | done_o (one cycle)   | partial_sum_o
//   config   | psel/penable/pwrite  | paddr, pwdata, prdata (decimation_ratio)
//
// One request per cycle; busy_o stays low. A request passes the request register,
// the lane coefficient register and the result register in that order, and done_o
// rises with the result held in the result register.
// The lane multipliers (two per lane) set the longest path.
// Reset clears the pipeline valid bits and sets the decimation ratio to 64.
// Results cannot be stalled; done_o is a one-cycle strobe.
`timescale 1ns / 1ps
`default_nettype none

module sinc3_pdm_lut_entry_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic [7:0]                           pdm_byte_i,
  input  logic [3:0]                           tap_group_i,
  input  logic [1:0]                           stage_index_i,
  output logic                                 done_o,
  output logic [s3lut_pkg::SUM_W-1:0]          partial_sum_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [s3lut_pkg::ADDR_W-1:0]         paddr,
  input  logic [s3lut_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [s3lut_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                 pready
);

  logic [s3lut_pkg::RATIO_W-1:0] ratio_q;
  logic                          cfg_hit;
  logic                          req_accept;

  logic                          v0_q;
  logic [7:0]                    byte_q;
  logic [3:0]                    group_q;
  logic [1:0]                    stage_q;

  logic [s3lut_pkg::RATIO_W-1:0] d_sat;
  logic                          entry_en;
  logic [s3lut_pkg::POS_W-1:0]   stage_off;
  logic [s3lut_pkg::POS_W-1:0]   base;
  s3lut_pkg::coef_vec_t          lane_coef;
  s3lut_pkg::coef_vec_t          coef_d;
  s3lut_pkg::coef_vec_t          coef_q;
  logic                          v1_q;

  logic [s3lut_pkg::SUM_W-1:0]   sum_d;
  logic [s3lut_pkg::SUM_W-1:0]   sum_q;
  logic                          done_q;

  // config register
  assign pready  = 1'b1;
  assign cfg_hit = paddr[s3lut_pkg::ADDR_W-1:2] == s3lut_pkg::REG_DECIMATION;
  assign prdata  = cfg_hit ? {{(s3lut_pkg::APB_DATA_W-s3lut_pkg::RATIO_W){1'b0}}, ratio_q}
                           : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q <= s3lut_pkg::RATIO_W'(s3lut_pkg::RATIO_RESET);
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      ratio_q <= pwdata[s3lut_pkg::RATIO_W-1:0];
    end
  end

  assign busy_o     = 1'b0;
  assign req_accept = start_i && !busy_o;

  // request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= req_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_accept) begin
      byte_q  <= pdm_byte_i;
      group_q <= tap_group_i;
      stage_q <= stage_index_i;
    end
  end

  assign d_sat = (ratio_q > s3lut_pkg::RATIO_W'(s3lut_pkg::MAX_DECIMATION))
                 ? s3lut_pkg::RATIO_W'(s3lut_pkg::MAX_DECIMATION) : ratio_q;

  // groups at or past D/8 and the unused stage code give zero
  assign entry_en = (stage_q < 2'(s3lut_pkg::STAGES))
                    && ({1'b0, group_q} < d_sat[s3lut_pkg::RATIO_W-1:3]);

  always_comb begin
    case (stage_q)
      2'd0:    stage_off = '0;
      2'd1:    stage_off = {1'b0, d_sat};
      default: stage_off = {d_sat, 1'b0};
    endcase
  end

  assign base = stage_off + {2'b00, group_q, 3'b000};

  for (genvar i = 0; i < s3lut_pkg::LANES; i++) begin : g_lane
    s3lut_coef u_coef (
      .pos_i   (base + s3lut_pkg::POS_W'(i)),
      .ratio_i (d_sat),
      .coef_o  (lane_coef[i])
    );

    // MSB of the byte weights the first tap of the group
    assign coef_d[i] = (entry_en && byte_q[s3lut_pkg::LANES-1-i]) ? lane_coef[i] : '0;
  end

  // lane coefficient register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v0_q) begin
      coef_q <= coef_d;
    end
  end

  s3lut_sum u_sum (
    .coef_i (coef_q),
    .sum_o  (sum_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      sum_q <= sum_d;
    end
  end

  assign done_o        = done_q;
  assign partial_sum_o = sum_q;

endmodule

`default_nettype wire

// File: hdl/s3lut_coef.sv
// One sinc3 kernel coefficient from a kernel tap position and box length.
// Depends on s3lut_pkg.
`timescale 1ns / 1ps
`default_nettype none

module s3lut_coef (
  input  logic [s3lut_pkg::POS_W-1:0]   pos_i,
  input  logic [s3lut_pkg::RATIO_W-1:0] ratio_i,
  output logic [s3lut_pkg::COEF_W-1:0]  coef_o
);

  logic [s3lut_pkg::POS_W:0]     d3;
  logic [s3lut_pkg::POS_W:0]     last;
  logic [s3lut_pkg::POS_W-1:0]   d2;
  logic [s3lut_pkg::POS_W-1:0]   n;
  logic [s3lut_pkg::POS_W:0]     m;
  logic [s3lut_pkg::POS_W-1:0]   x;
  logic [s3lut_pkg::RATIO_W-1:0] k;
  logic                          edge_tap;
  logic                          in_first;
  logic                          in_last;
  logic [19:0]                   prod_x;
  logic [19:0]                   prod_k;
  logic [18:0]                   tri_x;
  logic [18:0]                   tri_k3;
  logic [18:0]                   coef;

  assign d3       = ({2'b00, ratio_i} << 1) + {2'b00, ratio_i};
  assign last     = d3 - 10'd1;
  assign d2       = {ratio_i, 1'b0};
  assign n        = pos_i - 9'd1;
  assign edge_tap = (pos_i == '0) || ({1'b0, pos_i} >= last);
  assign in_first = n < {1'b0, ratio_i};
  assign in_last  = n >= d2;

  // mirror the falling edge of the kernel onto the rising one
  assign m = d3 - 10'd3 - {1'b0, n};
  assign x = in_last ? m[s3lut_pkg::POS_W-1:0] : n;
  assign k = n[s3lut_pkg::RATIO_W-1:0] - ratio_i;

  assign prod_x = (20'(x) + 20'd1) * (20'(x) + 20'd2);
  assign prod_k = (20'(k) + 20'd1) * (20'(k) + 20'd2);
  assign tri_x  = prod_x[19:1];
  assign tri_k3 = prod_k[19:1] + {1'b0, prod_k[17:1], 1'b0};

  always_comb begin
    if (edge_tap) begin
      coef = '0;
    end else if (in_first || in_last) begin
      coef = tri_x;
    end else begin
      coef = tri_x - tri_k3;
    end
  end

  assign coef_o = coef[s3lut_pkg::COEF_W-1:0];

endmodule

`default_nettype wire

// File: hdl/s3lut_sum.sv
// Adder tree over the masked lane coefficients with saturation to the output width.
// Depends on s3lut_pkg.
`timescale 1ns / 1ps
`default_nettype none

module s3lut_sum (
  input  s3lut_pkg::coef_vec_t         coef_i,
  output logic [s3lut_pkg::SUM_W-1:0]  sum_o
);

  logic [s3lut_pkg::COEF_W:0]   lvl1 [4];
  logic [s3lut_pkg::COEF_W+1:0] lvl2 [2];
  logic [s3lut_pkg::COEF_W+2:0] total;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      lvl1[j] = {1'b0, coef_i[2*j]} + {1'b0, coef_i[2*j+1]};
    end
    for (int j = 0; j < 2; j++) begin
      lvl2[j] = {1'b0, lvl1[2*j]} + {1'b0, lvl1[2*j+1]};
    end
    total = {1'b0, lvl2[0]} + {1'b0, lvl2[1]};
  end

  // clamp at the largest value the result field holds
  assign sum_o = (total > 19'(s3lut_pkg::SUM_MAX)) ? s3lut_pkg::SUM_W'(s3lut_pkg::SUM_MAX)
                                                 : total[s3lut_pkg::SUM_W-1:0];

endmodule

`default_nettype wire

// File: hdl/s3lut_checker.sv
// Port-level checks for the sinc3 PDM LUT entry unit, bound to the top level.
// Depends on s3lut_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module s3lut_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start_i,
  input logic                        busy_i,
  input logic [7:0]                  pdm_byte_i,
  input logic [1:0]                  stage_index_i,
  input logic                        done_i,
  input logic [s3lut_pkg::SUM_W-1:0] partial_sum_i
);

  `S3_ASSERT(a_never_busy, clk_i, rst_ni, !busy_i)

  // every request gives exactly one result, and no result comes without a request
  `S3_ASSERT(a_fixed_latency, clk_i, rst_ni, done_i == ($past(start_i && !busy_i, 3) && $past(rst_ni, 3) && $past(rst_ni, 2) && $past(rst_ni, 1)))

  `S3_IMPLY(a_empty_byte, clk_i, rst_ni, done_i && ($past(pdm_byte_i, 3) == 8'd0), partial_sum_i == '0)

  `S3_IMPLY(a_unused_stage, clk_i, rst_ni, done_i && ($past(stage_index_i, 3) >= 2'(s3lut_pkg::STAGES)), partial_sum_i == '0)

endmodule

bind sinc3_pdm_lut_entry_unit s3lut_checker u_s3lut_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_i        (busy_o),
  .pdm_byte_i    (pdm_byte_i),
  .stage_index_i (stage_index_i),
  .done_i        (done_o),
  .partial_sum_i (partial_sum_o)
);

`default_nettype wire
